/* rtl/rebe_pkg.sv */
// Shared types and constants for the rotary encoder / push switch event block.
// No dependencies; the design modules refer to this package by scoped names; the testbench imports it.
`default_nettype none

package rebe_pkg;

    localparam int unsigned HOLD_W  = 10;
    localparam int unsigned COUNT_W = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;
    localparam logic [HOLD_W-1:0]  HOLD_TICKS_RESET = 10'd100;

    localparam logic SW_RELEASED = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EVENTS_ENABLED = 1'b1;

    typedef struct packed {
        logic click;
        logic hold;
        logic long_hold;
    } switch_flags_t;

    typedef struct packed {
        logic left;
        logic right;
    } turn_flags_t;

    typedef struct packed {
        logic event_click;
        logic event_hold;
        logic event_long_hold;
        logic turn_left;
        logic turn_right;
    } result_t;

endpackage

`default_nettype wire

/* rtl/rebe_ifs.sv */
// Valid/ready channel interfaces: sample ticks in, event items out.
// No dependencies.
`default_nettype none

interface rebe_tick_if;
    logic valid;
    logic ready;
    logic switch_level;
    logic line_a;
    logic line_b;

    modport source (output valid, output switch_level, output line_a, output line_b,
                    input ready);
    modport sink   (input valid, input switch_level, input line_a, input line_b,
                    output ready);
endinterface

interface rebe_result_if;
    logic valid;
    logic ready;
    logic event_click;
    logic event_hold;
    logic event_long_hold;
    logic turn_left;
    logic turn_right;

    modport source (output valid, output event_click, output event_hold,
                    output event_long_hold, output turn_left, output turn_right,
                    input ready);
    modport sink   (input valid, input event_click, input event_hold,
                    input event_long_hold, input turn_left, input turn_right,
                    output ready);
endinterface

`default_nettype wire

/* rtl/rebe_switch.sv */
// Push switch tracker: press count, long-hold phase and switch flags per tick.
// Depends on rebe_pkg.
`default_nettype none

module rebe_switch (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           tick_fire,
    input  wire logic                           switch_level,
    input  wire logic [rebe_pkg::HOLD_W-1:0]    hold_ticks,
    output rebe_pkg::switch_flags_t             flags
);

    logic                          prev_switch_reg, prev_switch_next;
    logic [rebe_pkg::COUNT_W-1:0]  press_count_reg, press_count_next;
    logic [rebe_pkg::HOLD_W-1:0]   period_phase_reg, period_phase_next;

    logic                          press_start;
    logic [rebe_pkg::COUNT_W-1:0]  count_base;
    logic [rebe_pkg::HOLD_W-1:0]   phase_step;

    always_comb
    begin
        press_start = (prev_switch_reg == rebe_pkg::SW_RELEASED);
        // restart both counters on the first tick of a press
        count_base  = press_start ? '0 : press_count_reg;
        phase_step  = (press_start ? '0 : period_phase_reg) + 1'b1;

        flags             = '0;
        prev_switch_next  = prev_switch_reg;
        press_count_next  = press_count_reg;
        period_phase_next = period_phase_reg;

        if (tick_fire)
        begin
            prev_switch_next = switch_level;
            if (switch_level == rebe_pkg::SW_RELEASED)
            begin
                if (!press_start)
                begin
                    flags.click     = 1'b1;
                    flags.long_hold = (press_count_reg > {1'b0, hold_ticks});
                end
            end
            else
            begin
                flags.hold = 1'b1;
                // saturate the press length
                press_count_next = (count_base == rebe_pkg::COUNT_MAX) ?
                                   count_base : count_base + 1'b1;
                if (phase_step >= hold_ticks)
                begin
                    period_phase_next = '0;
                    flags.long_hold   = 1'b1;
                end
                else
                begin
                    period_phase_next = phase_step;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_switch_reg  <= rebe_pkg::SW_RELEASED;
            press_count_reg  <= '0;
            period_phase_reg <= '0;
        end
        else
        begin
            prev_switch_reg  <= prev_switch_next;
            press_count_reg  <= press_count_next;
            period_phase_reg <= period_phase_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/rebe_quad.sv */
// Quadrature decoder: one detent per tick where A equals B and the pair moved.
// Depends on rebe_pkg.
`default_nettype none

module rebe_quad (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              tick_fire,
    input  wire logic              line_a,
    input  wire logic              line_b,
    output rebe_pkg::turn_flags_t  flags
);

    logic [1:0] prev_lines_reg, prev_lines_next;
    logic [1:0] cur_lines;
    logic       detent;

    always_comb
    begin
        cur_lines       = {line_a, line_b};
        detent          = (line_a == line_b) && (cur_lines != prev_lines_reg);
        prev_lines_next = tick_fire ? cur_lines : prev_lines_reg;
        // direction follows the previous B level
        flags.left      = tick_fire && detent && (prev_lines_reg[0] == line_b);
        flags.right     = tick_fire && detent && (prev_lines_reg[0] != line_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_lines_reg <= '0;
        end
        else
        begin
            prev_lines_reg <= prev_lines_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/rebe_out_skid.sv */
// Result register with one skid entry between the event logic and the consumer.
// Depends on rebe_pkg.
`default_nettype none

module rebe_out_skid (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire rebe_pkg::result_t  push_data,
    output logic                    can_push,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output rebe_pkg::result_t       out_data
);

    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    rebe_pkg::result_t  out_data_reg, out_data_next;
    rebe_pkg::result_t  skid_data_reg, skid_data_next;
    logic               pop;

    always_comb
    begin
        pop             = out_valid_reg && out_ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_data_next = push_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register empty");

    skid_blocks_push: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("item pushed while skid entry full");

    stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

/* rtl/rotary_encoder_button_events_core.sv */
// Rotary encoder with push switch: turns sample ticks into click/hold/turn items.
// Each item is registered in the result register, or in the skid entry while output stalls.
// Throughput: one tick per cycle; ready drops only while the skid entry is full.
// Reset (rst_n, async low) clears all history and output entries; hold_ticks 100, events off.
// Depends on rebe_pkg, rebe_ifs, rebe_switch, rebe_quad and rebe_out_skid.
`default_nettype none

module rotary_encoder_button_events_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [rebe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rebe_pkg::HOLD_W-1:0]       cfg_data,
    rebe_tick_if.sink                              tick,
    rebe_result_if.source                          result
);

    // Configuration registers
    logic [rebe_pkg::HOLD_W-1:0] hold_ticks_reg, hold_ticks_next;
    logic                        events_enabled_reg, events_enabled_next;

    logic                        tick_accept;
    logic                        tick_fire;
    logic                        can_push;
    logic                        push;
    rebe_pkg::switch_flags_t     sw_flags;
    rebe_pkg::turn_flags_t       turn_flags;
    rebe_pkg::result_t           push_data;
    rebe_pkg::result_t           out_data;

    // Decode register writes
    always_comb
    begin
        hold_ticks_next     = hold_ticks_reg;
        events_enabled_next = events_enabled_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rebe_pkg::REG_HOLD_TICKS:     hold_ticks_next     = cfg_data;
                rebe_pkg::REG_EVENTS_ENABLED: events_enabled_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg     <= rebe_pkg::HOLD_TICKS_RESET;
            events_enabled_reg <= 1'b0;
        end
        else
        begin
            hold_ticks_reg     <= hold_ticks_next;
            events_enabled_reg <= events_enabled_next;
        end
    end

    // Accept a tick whenever the skid entry is free; a disabled tick is
    // taken and dropped without touching any history.
    assign tick.ready  = can_push;
    assign tick_accept = tick.valid && tick.ready;
    assign tick_fire   = tick_accept && events_enabled_reg;

    rebe_switch u_switch (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_fire    (tick_fire),
        .switch_level (tick.switch_level),
        .hold_ticks   (hold_ticks_reg),
        .flags        (sw_flags)
    );

    rebe_quad u_quad (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_fire (tick_fire),
        .line_a    (tick.line_a),
        .line_b    (tick.line_b),
        .flags     (turn_flags)
    );

    // Assemble the item; hold alone is not worth an item.
    always_comb
    begin
        push_data.event_click     = sw_flags.click;
        push_data.event_hold      = sw_flags.hold;
        push_data.event_long_hold = sw_flags.long_hold;
        push_data.turn_left       = turn_flags.left;
        push_data.turn_right      = turn_flags.right;
        push = tick_fire && (sw_flags.click || sw_flags.long_hold ||
                             turn_flags.left || turn_flags.right);
    end

    rebe_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .can_push  (can_push),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (out_data)
    );

    assign result.event_click     = out_data.event_click;
    assign result.event_hold      = out_data.event_hold;
    assign result.event_long_hold = out_data.event_long_hold;
    assign result.turn_left       = out_data.turn_left;
    assign result.turn_right      = out_data.turn_right;

    no_hold_only_item: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.event_click || result.event_long_hold ||
                          result.turn_left || result.turn_right))
        else $error("item carries hold alone");

    one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.turn_left && result.turn_right))
        else $error("both turn directions in one item");

    click_not_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.event_click && result.event_hold))
        else $error("click and hold in one item");

    disabled_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        !events_enabled_reg |-> !push)
        else $error("item produced while events disabled");

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for rotary_encoder_button_events_core: sample ticks in,
// click/hold/turn items out, checked against an in-bench event predictor.
// Depends on rebe_pkg, rebe_ifs and the block's RTL.
`default_nettype none

module tb;
    import rebe_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_REPORTS = 40;

    // one sample tick as the sender sees it
    typedef struct packed {
        logic switch_level;
        logic line_a;
        logic line_b;
    } sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_HOLD_TICKS;
    logic [HOLD_W-1:0] cfg_data = '0;

    rebe_tick_if tick_ch();
    rebe_result_if evt_ch();

    rotary_encoder_button_events_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .result    (evt_ch)
    );

    // Stimulus and scoreboard storage
    sample_t pending_ticks[$];
    result_t expected_events[$];

    // Idle percentages for the two sides, changed only between phases
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Handshake flag: set at the rising edge that takes a tick, consumed by the driver
    bit tick_taken = 1'b0;

    int unsigned cycle_count = 0;
    int unsigned ticks_accepted = 0;
    int unsigned events_checked = 0;
    int unsigned fail_count = 0;

    // Predictor state: configuration and switch/line history
    logic [HOLD_W-1:0]  hold_period = HOLD_TICKS_RESET;
    logic               enabled = 1'b0;
    logic               last_switch = SW_RELEASED;
    logic [COUNT_W-1:0] press_ticks = '0;
    logic [HOLD_W-1:0]  mark_phase = '0;
    logic [1:0]         last_lines = 2'b00;

    // Generator state for well-formed random sequences
    logic [1:0]  gen_lines = 2'b00;
    bit          gen_clockwise = 1'b1;
    int unsigned gen_press_left = 0;

    // Clock
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: one accepted tick in, at most one event item out.
    // Returns 1 when the tick yields an item.
    // ------------------------------------------------------------------
    function automatic bit predict_events(input sample_t s, output result_t r);
        logic       was_up;
        logic [1:0] now_lines;
        logic [1:0] was_lines;
        r = '0;
        // disabled ticks leave every piece of history untouched
        if (!enabled)
            return 1'b0;

        was_up = last_switch;
        last_switch = s.switch_level;
        if (s.switch_level == SW_RELEASED && was_up != SW_RELEASED)
        begin
            // release: counters are kept; a press longer than the period is long
            r.event_click = 1'b1;
            if (press_ticks > {1'b0, hold_period})
                r.event_long_hold = 1'b1;
        end
        else if (s.switch_level != SW_RELEASED)
        begin
            r.event_hold = 1'b1;
            // press begins: restart both counters, then count this tick
            if (was_up == SW_RELEASED)
            begin
                press_ticks = '0;
                mark_phase = '0;
            end
            if (press_ticks != COUNT_MAX)
                press_ticks = press_ticks + 1'b1;
            mark_phase = mark_phase + 1'b1;
            // ">=" also covers a period lowered mid-press and a zero period
            if (mark_phase >= hold_period)
            begin
                mark_phase = '0;
                r.event_long_hold = 1'b1;
            end
        end

        // rotation: a detent lands where A equals B and the pair moved;
        // direction comes from the previous B bit
        now_lines = {s.line_a, s.line_b};
        was_lines = last_lines;
        last_lines = now_lines;
        if (s.line_a == s.line_b && now_lines != was_lines)
        begin
            if (was_lines[0] == s.line_b)
                r.turn_left = 1'b1;
            else
                r.turn_right = 1'b1;
        end

        // hold on its own never makes an item
        return r.event_click | r.event_long_hold | r.turn_left | r.turn_right;
    endfunction

    task automatic check_field(input string name, input logic want, input logic got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0b, actual %0b",
                         $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample at the rising edge. Track config writes, predict
    // accepted ticks, and check each accepted event item against the
    // oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        result_t predicted;
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HOLD_TICKS:     hold_period = cfg_data;
                    REG_EVENTS_ENABLED: enabled = cfg_data[0];
                    default: ;
                endcase
            end

            if (tick_ch.valid && tick_ch.ready)
            begin
                tick_taken = 1'b1;
                ticks_accepted++;
                if (predict_events({tick_ch.switch_level, tick_ch.line_a, tick_ch.line_b},
                                   predicted))
                    expected_events.push_back(predicted);
            end

            if (evt_ch.valid && evt_ch.ready)
            begin
                got = {evt_ch.event_click, evt_ch.event_hold, evt_ch.event_long_hold,
                       evt_ch.turn_left, evt_ch.turn_right};
                events_checked++;
                if (expected_events.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected item, expected none, actual %05b",
                                 $time, got);
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_click", want.event_click, got.event_click);
                    check_field("event_hold", want.event_hold, got.event_hold);
                    check_field("event_long_hold", want.event_long_hold,
                                got.event_long_hold);
                    check_field("turn_left", want.turn_left, got.turn_left);
                    check_field("turn_right", want.turn_right, got.turn_right);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge. Advance to the next
    // pending tick only once the current one was taken; idle at random.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        sample_t next_tick;
        if (!rst_n)
        begin
            tick_ch.valid <= 1'b0;
            evt_ch.ready <= 1'b0;
        end
        else
        begin
            if (!tick_ch.valid || tick_taken)
            begin
                tick_taken = 1'b0;
                if (pending_ticks.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    next_tick = pending_ticks.pop_front();
                    tick_ch.valid <= 1'b1;
                    tick_ch.switch_level <= next_tick.switch_level;
                    tick_ch.line_a <= next_tick.line_a;
                    tick_ch.line_b <= next_tick.line_b;
                end
                else
                begin
                    tick_ch.valid <= 1'b0;
                end
            end
            evt_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_tick(input logic sw, input logic a, input logic b);
        pending_ticks.push_back('{switch_level: sw, line_a: a, line_b: b});
    endtask

    // Move the generator's line pair: mostly one Gray step in the current
    // direction, sometimes stay, sometimes jump anywhere (noise).
    task automatic step_lines();
        int unsigned roll;
        logic [1:0]  pos;
        roll = $urandom_range(99);
        if (roll < 8)
            gen_clockwise = ~gen_clockwise;
        if (roll < 60)
        begin
            pos = {gen_lines[1], gen_lines[1] ^ gen_lines[0]};
            pos = gen_clockwise ? pos + 2'd1 : pos - 2'd1;
            gen_lines = {pos[1], pos[1] ^ pos[0]};
        end
        else if (roll >= 85)
        begin
            gen_lines = 2'($urandom_range(3));
        end
    endtask

    // Random ticks shaped as presses of chosen length plus rotation, with
    // occasional switch bounce.
    task automatic gen_random(input int unsigned count, input int unsigned period);
        logic        sw;
        int unsigned top;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (gen_press_left != 0)
            begin
                sw = 1'b0;
                gen_press_left--;
            end
            else
            begin
                sw = SW_RELEASED;
                if ($urandom_range(99) < 12)
                begin
                    top = (period > 40) ? period + period / 4 + 3 : 3 * period + 4;
                    gen_press_left = ($urandom_range(99) < 60) ?
                                     $urandom_range(1, period + 2) :
                                     $urandom_range(period + 1, top);
                end
            end
            if ($urandom_range(99) < 4)
                sw = ~sw;
            step_lines();
            push_tick(sw, gen_lines[1], gen_lines[0]);
        end
    endtask

    // Hold the sender until every queued tick is taken and every expected
    // item has come, then let the pipeline empty.
    task automatic settle();
        while (pending_ticks.size() != 0 || tick_ch.valid)
            @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [HOLD_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        tick_ch.valid = 1'b0;
        tick_ch.switch_level = SW_RELEASED;
        tick_ch.line_a = 1'b0;
        tick_ch.line_b = 1'b0;
        evt_ch.ready = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender idles often, receiver stalls heavily
        send_idle_pct = 36;
        recv_idle_pct = 86;

        // Directed: short period so long holds show up quickly
        write_reg(REG_HOLD_TICKS, 10'd2);
        write_reg(REG_EVENTS_ENABLED, 10'd1);
        push_tick(1'b1, 1'b0, 1'b0);     // nothing moves
        push_tick(1'b1, 1'b0, 1'b1);     // A != B: no detent
        push_tick(1'b1, 1'b1, 1'b1);     // detent, left
        push_tick(1'b1, 1'b1, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);     // detent, left
        push_tick(1'b1, 1'b1, 1'b0);
        push_tick(1'b1, 1'b1, 1'b1);     // detent, right
        push_tick(1'b1, 1'b0, 1'b1);
        push_tick(1'b1, 1'b0, 1'b0);     // detent, right
        push_tick(1'b1, 1'b1, 1'b1);     // jump across two states
        push_tick(1'b1, 1'b1, 1'b1);     // unchanged pair: no detent
        push_tick(1'b0, 1'b1, 1'b1);     // press begins: hold only, no item
        push_tick(1'b0, 1'b1, 1'b1);     // period mark
        push_tick(1'b0, 1'b0, 1'b0);     // hold with a turn in the same tick
        push_tick(1'b1, 1'b0, 1'b0);     // release after a long press
        push_tick(1'b0, 1'b0, 1'b0);     // one-tick press
        push_tick(1'b1, 1'b0, 1'b0);     // plain click
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);     // mark at exactly the period
        push_tick(1'b1, 1'b0, 1'b0);     // count equals period: click without long hold
        settle();

        // Zero period: every held tick is a mark
        write_reg(REG_HOLD_TICKS, 10'd0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b1);
        push_tick(1'b1, 1'b1, 1'b1);
        settle();

        write_reg(REG_HOLD_TICKS, 10'd1);
        gen_random(200, 1);
        settle();

        write_reg(REG_HOLD_TICKS, 10'd7);
        gen_random(150, 7);
        // sender pauses mid-phase until all outstanding items are back
        settle();
        gen_random(150, 7);
        settle();

        // receiver stalls less than sender now
        send_idle_pct = 86;
        recv_idle_pct = 36;

        // Disabled: ticks are dropped and must not touch history
        write_reg(REG_EVENTS_ENABLED, 10'd0);
        gen_random(40, 7);
        settle();
        write_reg(REG_EVENTS_ENABLED, 10'd1);

        write_reg(REG_HOLD_TICKS, 10'd1000);
        gen_random(250, 1000);
        // leave a press open across the next write
        gen_press_left = 0;
        for (int i = 0; i < 40; i++)
        begin
            step_lines();
            push_tick(1'b0, gen_lines[1], gen_lines[0]);
        end
        settle();

        // Period lowered while the switch is still down
        write_reg(REG_HOLD_TICKS, 10'd3);
        for (int i = 0; i < 10; i++)
        begin
            step_lines();
            push_tick(1'b0, gen_lines[1], gen_lines[0]);
        end
        gen_random(250, 3);
        settle();

        write_reg(REG_HOLD_TICKS, 10'd20);
        gen_random(250, 20);
        settle();

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;

        write_reg(REG_HOLD_TICKS, 10'd5);
        gen_random(300, 5);
        settle();

        write_reg(REG_HOLD_TICKS, 10'd2);
        gen_random(200, 2);
        settle();

        repeat (8) @(posedge clk);
        $display("Run covered %0d ticks and %0d event items across periods 0 to 1000,",
                 ticks_accepted, events_checked);
        $display("with disabled ticks, a press held across a period change and idling.");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

/* rotary_encoder_button_events_core.f */
rtl/rebe_pkg.sv
rtl/rebe_ifs.sv
rtl/rebe_switch.sv
rtl/rebe_quad.sv
rtl/rebe_out_skid.sv
rtl/rotary_encoder_button_events_core.sv
test/tb.sv
